FILE: hw/rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants of the frame stability detector: field widths,
// register indexes and reset values, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fsd_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int REL_W    = 8;
    localparam int ABS_W    = 8;
    localparam int AGE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Spread arithmetic
    localparam int LO_W     = SAMPLE_W + 1;
    localparam int PROD_A_W = SAMPLE_W + 7;
    localparam int PROD_B_W = SAMPLE_W + REL_W + 1;
    localparam logic [LO_W-1:0]     MIN_START = LO_W'(1024);
    localparam logic [SAMPLE_W-1:0] MAX_START = SAMPLE_W'(1);
    localparam logic [6:0]          PERCENT   = 7'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 2'd2;

    // Register reset values
    localparam logic [REL_W-1:0] REL_RESET = 8'd25;
    localparam logic [ABS_W-1:0] ABS_RESET = 8'd5;
    localparam logic [AGE_W-1:0] AGE_RESET = 16'd10000;

    // Controller states
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_MULT  = 6'b010000,
        ST_CHECK = 6'b100000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_we;   // write one zero entry of the clearing pass
        logic accept;   // take the input item
        logic scan;     // issue one history read
        logic mult;     // form the spread products
        logic check;    // apply the pin test, finish the item
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last; // clearing pass at its final entry
        logic pin_room; // current pin is within the frame width
        logic row_last; // final history slot being read
        logic last;     // item held marks the end of a frame
        logic out_busy; // result register full and not being taken
    } t_ctrl_sts;

endpackage

FILE: hw/rtl/fsd_ram.sv
// ----------------------------------------------------------------------------
// fsd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fsd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 200
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fsd_ctrl.sv
// ----------------------------------------------------------------------------
// fsd_ctrl
// Controller of the frame stability detector: runs the clearing pass after
// reset, then steps each accepted item through history scan, spread products
// and pin check.
// ----------------------------------------------------------------------------
module fsd_ctrl
    import fsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.pin_room ? ST_SCAN : ST_CHECK;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.row_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_MULT;
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // hold while a finished result still waits to be taken
                if (!(i_sts.last && i_sts.out_busy)) begin
                    o_cmd.check = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

`ifndef SYNTHESIS
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SCAN || r_state == ST_CHECK))
        else $error("accepted item did not enter scan or check");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_state != ST_CLEAR))
        else $error("clearing pass re-entered without reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && i_sts.last && i_sts.out_busy) |=> (r_state == ST_CHECK))
        else $error("frame end left check while the result register was full");
`endif

endmodule

FILE: hw/rtl/fsd_datapath.sv
// ----------------------------------------------------------------------------
// fsd_datapath
// Datapath of the frame stability detector: history RAM, frame time ring,
// per-pin min/max scan, spread test, configuration and result registers.
// ----------------------------------------------------------------------------
module fsd_datapath
    import fsd_pkg::*;
#(
    parameter int HISTORY = 5,
    parameter int PINS    = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_sts             o_sts,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [TIME_W-1:0]     i_time_ms,
    input  logic                  i_frame_end,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_steady,
    output logic                  o_too_old
);

    localparam int DEPTH = HISTORY * PINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(HISTORY);
    localparam int PW    = $clog2(PINS + 1);

    // Configuration registers
    logic [REL_W-1:0] r_rel_limit;
    logic [ABS_W-1:0] r_abs_limit;
    logic [AGE_W-1:0] r_age_limit;

    // Frame control
    logic [SW-1:0]     r_slot;
    logic [AW-1:0]     r_slot_base;
    logic [PW-1:0]     r_pin;
    logic              r_running_ok;
    logic              r_stale;
    logic [TIME_W-1:0] r_times [HISTORY];
    logic [SW-1:0]     oldest;
    logic [TIME_W-1:0] age;

    // Item held
    logic r_test;
    logic r_last;

    // Scan
    logic [AW-1:0]       r_clr_addr;
    logic [SW-1:0]       r_row;
    logic [AW-1:0]       r_row_base;
    logic                r_rd_pend;
    logic [SAMPLE_W-1:0] r_hi;
    logic [LO_W-1:0]     r_lo;
    logic [SAMPLE_W-1:0] rd_data;
    logic [LO_W-1:0]     rd_ext;

    // Spread test
    logic [LO_W-1:0]     diff;
    logic [SAMPLE_W-1:0] spread;
    logic [SAMPLE_W-1:0] r_spread;
    logic [PROD_A_W-1:0] r_prod_a;
    logic [PROD_B_W-1:0] r_prod_b;
    logic                pin_fail;
    logic                ok_now;

    // Result register
    logic r_out_valid;
    logic r_steady;
    logic r_too_old;

    // RAM ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_limit <= REL_RESET;
            r_abs_limit <= ABS_RESET;
            r_age_limit <= AGE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REL_LIMIT: r_rel_limit <= i_cfg_data[REL_W-1:0];
                CFG_ABS_LIMIT: r_abs_limit <= i_cfg_data[ABS_W-1:0];
                CFG_AGE_LIMIT: r_age_limit <= i_cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // History RAM: clearing pass, then sample writes and scan reads
    assign ram_we    = i_cmd.clr_we || (i_cmd.accept && o_sts.pin_room);
    assign ram_waddr = i_cmd.clr_we ? r_clr_addr : (r_slot_base + AW'(r_pin));
    assign ram_wdata = i_cmd.clr_we ? '0 : i_sample;
    assign ram_raddr = r_row_base + AW'(r_pin);

    fsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Advance the clearing address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Age of the oldest frame against the new timestamp
    assign oldest = (r_slot == SW'(HISTORY - 1)) ? '0 : r_slot + SW'(1);
    assign age    = i_time_ms - r_times[oldest];

    // Frame time ring; stamp on the first item of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY; i++) begin
                r_times[i] <= '0;
            end
        end else if (i_cmd.accept && (r_pin == '0)) begin
            r_times[r_slot] <= i_time_ms;
        end
    end

    // Hold the item's flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_test <= o_sts.pin_room;
            r_last <= i_frame_end;
        end
    end

    // Scan rows: one slot of the current pin per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_row      <= '0;
            r_row_base <= '0;
        end else if (i_cmd.scan) begin
            r_row      <= r_row + SW'(1);
            r_row_base <= r_row_base + AW'(PINS);
        end
    end

    // Accumulate min and max of returned reads
    assign rd_ext = LO_W'(rd_data);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hi <= MAX_START;
            r_lo <= MIN_START;
        end else if (r_rd_pend) begin
            if (rd_data > r_hi) begin
                r_hi <= rd_data;
            end
            if (rd_ext < r_lo) begin
                r_lo <= rd_ext;
            end
        end
    end

    // Spread and products; floor(s*100/hi) <= rel  is  s*100 < (rel+1)*hi
    assign diff   = LO_W'(r_hi) - r_lo;
    assign spread = (LO_W'(r_hi) >= r_lo) ? diff[SAMPLE_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_spread <= spread;
            r_prod_a <= PROD_A_W'(spread) * PROD_A_W'(PERCENT);
            r_prod_b <= PROD_B_W'({1'b0, r_rel_limit} + 9'd1) * PROD_B_W'(r_hi);
        end
    end

    assign pin_fail = r_test && (PROD_B_W'(r_prod_a) >= r_prod_b)
                      && (r_spread > SAMPLE_W'(r_abs_limit));
    assign ok_now   = r_running_ok && !pin_fail;

    // Frame state: pin count, running verdict, staleness, slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= '0;
            r_slot_base  <= '0;
            r_pin        <= '0;
            r_running_ok <= 1'b1;
            r_stale      <= 1'b0;
        end else begin
            if (i_cmd.accept && (r_pin == '0)) begin
                r_stale <= (age > TIME_W'(r_age_limit));
            end
            if (i_cmd.check) begin
                if (r_last) begin
                    r_pin        <= '0;
                    r_running_ok <= 1'b1;
                    r_stale      <= 1'b0;
                    if (r_slot == SW'(HISTORY - 1)) begin
                        r_slot      <= '0;
                        r_slot_base <= '0;
                    end else begin
                        r_slot      <= r_slot + SW'(1);
                        r_slot_base <= r_slot_base + AW'(PINS);
                    end
                end else begin
                    r_running_ok <= ok_now;
                    if (r_test) begin
                        r_pin <= r_pin + PW'(1);
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.check && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check && r_last) begin
            r_steady  <= ok_now && !r_stale;
            r_too_old <= r_stale;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_steady    = r_steady;
    assign o_too_old   = r_too_old;

    // Status
    assign o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.pin_room = (r_pin < PW'(PINS));
    assign o_sts.row_last = (r_row == SW'(HISTORY - 1));
    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

`ifndef SYNTHESIS
    a_pin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pin <= PW'(PINS))
        else $error("pin counter beyond frame width");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mult |-> (LO_W'(r_hi) >= r_lo))
        else $error("scan finished with max below min");

    a_result_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.check && !r_last && !r_out_valid) |=> !r_out_valid)
        else $error("result raised by an item without frame end");
`endif

endmodule

FILE: hw/rtl/frame_stability_detector_core.sv
// ----------------------------------------------------------------------------
// frame_stability_detector_core
// Each accepted item steps through scan, drain, product and check states;
// items beyond the frame width go straight to check. A frame end item loads
// the result register in check, held there while the last result waits. No
// item is taken before the last is done; the single history RAM read port
// fetches one stored slot of the pin per cycle. Reset: synchronous, active
// low; a clearing pass zeroes all HISTORY*PINS RAM entries before any item.
// ----------------------------------------------------------------------------
module frame_stability_detector_core
    import fsd_pkg::*;
#(
    parameter int HISTORY = 5,
    parameter int PINS    = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input item transfer
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [TIME_W-1:0]     i_time_ms,
    input  logic                  i_frame_end,
    // Result transfer
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_steady,
    output logic                  o_too_old,
    // Configuration write transfer
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    fsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fsd_datapath #(
        .HISTORY (HISTORY),
        .PINS    (PINS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    (i_sample),
        .i_time_ms   (i_time_ms),
        .i_frame_end (i_frame_end),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_steady    (o_steady),
        .o_too_old   (o_too_old)
    );

endmodule

FILE: bench/fsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_checker
// Watches the item, result and register write channels of the frame
// stability detector, keeps its own copy of the sample history, frame
// timestamps and limits, works out the verdict of every frame and compares
// each result transfer with the oldest verdict still outstanding.
// ----------------------------------------------------------------------------
module fsd_checker
    import fsd_pkg::*;
#(
    parameter int HISTORY = 5,
    parameter int PINS    = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [TIME_W-1:0]     i_time_ms,
    input  logic                  i_frame_end,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_steady,
    input  logic                  i_too_old,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic steady;
        logic too_old;
    } t_verdict;

    t_verdict verdict_q[$];

    // Mirror of the block's history and frame state
    logic [SAMPLE_W-1:0] sample_mem [HISTORY*PINS];
    logic [TIME_W-1:0]   stamp_mem  [HISTORY];
    int unsigned         slot_idx;
    int unsigned         pin_idx;
    logic                pins_ok;
    logic                stale;

    // Mirror of the limit registers
    logic [REL_W-1:0]    rel_limit;
    logic [ABS_W-1:0]    abs_limit;
    logic [AGE_W-1:0]    age_limit;

    int                  fail_count = 0;

    // Spread of one pin over every stored slot against both limits
    function automatic logic pin_within_limits(input int unsigned pin);
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        int unsigned spread;
        lo = int'(MIN_START);
        hi = int'(MAX_START);
        for (int r = 0; r < HISTORY; r++) begin
            v = sample_mem[r*PINS + pin];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        spread = (hi >= lo) ? hi - lo : 0;
        return ((spread * int'(PERCENT)) / hi <= rel_limit) || (spread <= abs_limit);
    endfunction

    task automatic clear_state();
        foreach (sample_mem[i]) sample_mem[i] = '0;
        foreach (stamp_mem[i]) stamp_mem[i] = '0;
        slot_idx  = 0;
        pin_idx   = 0;
        pins_ok   = 1'b1;
        stale     = 1'b0;
        rel_limit = REL_RESET;
        abs_limit = ABS_RESET;
        age_limit = AGE_RESET;
        verdict_q.delete();
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_REL_LIMIT: rel_limit = data[REL_W-1:0];
            CFG_ABS_LIMIT: abs_limit = data[ABS_W-1:0];
            CFG_AGE_LIMIT: age_limit = data[AGE_W-1:0];
            default: ;
        endcase
    endtask

    // Store one sample, test its pin and close the frame on its last sample
    task automatic track_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t,
                                input logic last);
        logic [TIME_W-1:0] age;
        if (pin_idx == 0) begin
            stamp_mem[slot_idx] = t;
            age   = t - stamp_mem[(slot_idx + 1) % HISTORY];
            stale = age > TIME_W'(age_limit);
        end
        if (pin_idx < PINS) begin
            sample_mem[slot_idx*PINS + pin_idx] = s;
            if (!pin_within_limits(pin_idx)) pins_ok = 1'b0;
            pin_idx++;
        end
        if (last) begin
            verdict_q.push_back('{steady: pins_ok && !stale, too_old: stale});
            slot_idx = (slot_idx + 1) % HISTORY;
            pin_idx  = 0;
            pins_ok  = 1'b1;
            stale    = 1'b0;
        end
    endtask

    task automatic check_verdict();
        t_verdict want;
        if (verdict_q.size() == 0) begin
            $display("%0t ns: result with none outstanding, expected nothing, %s",
                     $time, $sformatf("actual steady=%0b too_old=%0b", i_steady, i_too_old));
            fail_count++;
        end else begin
            want = verdict_q.pop_front();
            if (i_steady !== want.steady) begin
                $display("%0t ns: steady mismatch, expected %0b actual %0b",
                         $time, want.steady, i_steady);
                fail_count++;
            end
            if (i_too_old !== want.too_old) begin
                $display("%0t ns: too_old mismatch, expected %0b actual %0b",
                         $time, want.too_old, i_too_old);
                fail_count++;
            end
        end
    endtask

    // Follow every transfer seen at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) check_verdict();
            if (i_in_valid && i_in_ready) track_sample(i_sample, i_time_ms, i_frame_end);
        end
        o_fail_count <= fail_count;
        o_pending    <= verdict_q.size();
    end

endmodule

FILE: bench/frame_stability_detector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stability_detector_core_tb
// Feeds frames of pin samples to the detector in bursts while the result side
// stalls on its own pattern, moves the limits through several settings
// between phases, and leaves all checking to the checker beside the block.
// ----------------------------------------------------------------------------
module frame_stability_detector_core_tb;
    import fsd_pkg::*;

    localparam int HISTORY      = 5;
    localparam int PINS         = 40;
    localparam int PHASE_ITEMS  = 165;
    localparam int MIN_PHASES   = 7;
    localparam int SETTLE       = 2*HISTORY + 8;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic [TIME_W-1:0]     i_time_ms   = '0;
    logic                  i_frame_end = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_steady;
    logic                  o_too_old;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int                    fail_count;
    int                    pending;

    // Stimulus bookkeeping
    logic [SAMPLE_W-1:0]   pin_base    [PINS];
    logic [TIME_W-1:0]     sent_stamps [HISTORY];
    int unsigned           stamp_slot  = 0;
    int unsigned           frame_pos   = 0;
    int unsigned           burst_left  = 0;
    int unsigned           items_sent  = 0;
    logic                  steady_feed = 1'b0;
    logic [AGE_W-1:0]      cur_age     = AGE_RESET;
    int unsigned           rx_cycle    = 0;
    int unsigned           idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    frame_stability_detector_core #(
        .HISTORY (HISTORY),
        .PINS    (PINS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_time_ms   (i_time_ms),
        .i_frame_end (i_frame_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_steady    (o_steady),
        .o_too_old   (o_too_old),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    fsd_checker #(
        .HISTORY (HISTORY),
        .PINS    (PINS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_time_ms    (i_time_ms),
        .i_frame_end  (i_frame_end),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_steady     (o_steady),
        .i_too_old    (o_too_old),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result side: free flow, coin toss, fixed duty, mostly held
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 400) % 4)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= (rx_cycle % 7) < 2;
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Count cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Present one sample and hold it until the transfer
    task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t,
                             input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_sample    <= s;
        i_time_ms   <= t;
        i_frame_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (frame_pos == 0) sent_stamps[stamp_slot] = t;
        frame_pos++;
        items_sent++;
        if (last) begin
            stamp_slot = (stamp_slot + 1) % HISTORY;
            frame_pos  = 0;
        end
    endtask

    // Drop valid and wait for every outstanding verdict, then for the pipeline
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Pick the limits of a phase: widest, narrowest, plausible or anything
    task automatic load_limits(input int unsigned phase);
        logic [REL_W-1:0] rel;
        logic [ABS_W-1:0] abs_l;
        logic [AGE_W-1:0] age;
        if (phase == 1) begin
            rel   = '1;
            abs_l = '1;
            age   = '1;
        end else if (phase == 2) begin
            rel   = '0;
            abs_l = '0;
            age   = '0;
        end else if ($urandom_range(0, 1) == 1) begin
            rel   = REL_W'($urandom_range(5, 60));
            abs_l = ABS_W'($urandom_range(0, 20));
            age   = AGE_W'($urandom_range(2000, 20000));
        end else begin
            rel   = REL_W'($urandom);
            abs_l = ABS_W'($urandom);
            age   = AGE_W'($urandom);
        end
        if ($urandom_range(0, 2) == 0) put_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        put_reg(CFG_AGE_LIMIT, age);
        put_reg(CFG_REL_LIMIT, CFG_DATA_W'({8'($urandom), rel}));
        put_reg(CFG_ABS_LIMIT, CFG_DATA_W'({8'($urandom), abs_l}));
        i_cfg_valid <= 1'b0;
        cur_age = age;
    endtask

    // Short and single frames, sample extremes, stale and wrapped timestamps
    task automatic send_directed();
        send_item(10'd5,       32'd10000,      1'b0);
        send_item(10'd0,       $urandom,       1'b0);
        send_item(10'd3,       $urandom,       1'b0);
        send_item(10'd5,       $urandom,       1'b0);
        send_item(10'd4,       $urandom,       1'b0);
        send_item(10'd1,       $urandom,       1'b1);
        send_item(10'd6,       32'd10001,      1'b1);
        send_item(SAMPLE_W'(SAMPLE_MAX), 32'hFFFF_FFFF, 1'b0);
        send_item(10'd0,       32'h0000_0000,  1'b0);
        send_item(SAMPLE_W'(SAMPLE_MAX), $urandom, 1'b1);
        send_item(10'd0,       32'd0,          1'b0);
        send_item(10'd512,     32'hFFFF_FFFF,  1'b1);
        send_item(SAMPLE_W'(SAMPLE_MAX), 32'd5000, 1'b1);
    endtask

    // One frame: mostly full and close to the pin bases, some short, long or noisy
    task automatic send_frame();
        int unsigned       kind;
        int unsigned       len;
        int unsigned       pick;
        int                d;
        logic              noisy;
        logic [TIME_W-1:0] t0;
        logic [SAMPLE_W-1:0] s;
        kind = $urandom_range(0, 99);
        if (kind < 60)      len = PINS;
        else if (kind < 75) len = $urandom_range(1, PINS - 1);
        else if (kind < 85) len = PINS + $urandom_range(1, 6);
        else                len = $urandom_range(1, 3);

        pick = $urandom_range(0, 99);
        if (pick < 70)
            t0 = sent_stamps[(stamp_slot + HISTORY - 1) % HISTORY] + $urandom_range(0, 3000);
        else if (pick < 80)
            t0 = sent_stamps[(stamp_slot + 1) % HISTORY] + TIME_W'(cur_age) +
                 $urandom_range(0, 1);
        else if (pick < 90)
            t0 = $urandom;
        else
            t0 = 32'hFFFF_FFFF - $urandom_range(0, 2000);

        // Re-roll or nudge the pin levels now and then
        if ($urandom_range(0, 11) == 0) begin
            foreach (pin_base[p]) pin_base[p] = SAMPLE_W'($urandom);
        end else if ($urandom_range(0, 5) == 0) begin
            foreach (pin_base[p]) begin
                d = int'(pin_base[p]) + int'($urandom_range(0, 20)) - 10;
                pin_base[p] = SAMPLE_W'((d < 0) ? 0 : (d > SAMPLE_MAX) ? SAMPLE_MAX : d);
            end
        end

        noisy = ($urandom_range(0, 4) == 0);
        for (int unsigned p = 0; p < len; p++) begin
            if (noisy || p >= PINS) begin
                s = SAMPLE_W'($urandom);
            end else begin
                d = int'(pin_base[p]) + int'($urandom_range(0, 8)) - 4;
                s = SAMPLE_W'((d < 0) ? 0 : (d > SAMPLE_MAX) ? SAMPLE_MAX : d);
            end
            send_item(s, (p == 0) ? t0 : TIME_W'($urandom), p == len - 1);
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_start;
        foreach (pin_base[p]) pin_base[p] = SAMPLE_W'($urandom);
        foreach (sent_stamps[i]) sent_stamps[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits first, then a new setting per phase
        send_directed();
        phase = 0;
        do begin
            if (phase > 0) begin
                drain();
                load_limits(phase);
            end
            steady_feed = (phase % 3 == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_frame();
            phase++;
        end while (phase < MIN_PHASES);

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
